[design/lds_pkg.sv]
`timescale 1ns / 1ps

package lds_pkg;

   // Command codes of the result stream
   typedef enum logic [1:0] {
      CMD_DISABLE = 2'd0,
      CMD_DRAW    = 2'd1,
      CMD_ENABLE  = 2'd2
   } command_type;

   // Configuration register indexes
   localparam logic [1:0] REG_DIGIT_COUNT    = 2'd0;
   localparam logic [1:0] REG_SUBFIELD_COUNT = 2'd1;
   localparam logic [1:0] REG_SLEEPING       = 2'd2;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 16;
   localparam int GROUP_W      = 3;
   localparam int SEGMENTS_W   = 8;
   localparam int DIGIT_SUM_W  = 5;
   localparam int BUNDLE_DEPTH = 3;

   localparam logic [7:0] FULL_BRIGHTNESS = 8'hFF;

   typedef struct packed {
      logic [3:0] digit_count;
      logic [7:0] subfield_count;
      logic       sleeping;
   } cfg_type;

   typedef struct packed {
      command_type             command;
      logic [GROUP_W-1:0]      group;
      logic [SEGMENTS_W-1:0]   segments;
   } cmd_type;

   // Commands caused by one tick, entry 0 first
   typedef struct packed {
      cmd_type [BUNDLE_DEPTH-1:0] ent;
      logic [1:0]                 count;
   } bundle_type;

   function automatic cmd_type make_cmd(command_type c, logic [GROUP_W-1:0] g,
                                        logic [SEGMENTS_W-1:0] s);
      cmd_type r;
      r.command  = c;
      r.group    = g;
      r.segments = s;
      return r;
   endfunction

endpackage

[design/lds_core.sv]
`timescale 1ns / 1ps

module lds_core #(
   parameter int MAX_DIGITS   = 8,
   parameter int PATTERN_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               kind,
   input  logic [2:0]         digit_index,
   input  logic [7:0]         pattern_in,
   input  logic [7:0]         brightness_in,
   input  lds_pkg::cfg_type   cfg,
   output lds_pkg::bundle_type bundle
);
   import lds_pkg::*;

   localparam int DIGIT_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int PAT_W   = (PATTERN_BITS < 8) ? PATTERN_BITS : 8;

   logic [PAT_W-1:0]   pattern_ff [MAX_DIGITS];
   logic [7:0]         bright_ff  [MAX_DIGITS];
   logic [DIGIT_W-1:0] cur_digit_ff, cur_digit_in;
   logic [DIGIT_W-1:0] prev_digit_ff, prev_digit_in;
   logic [7:0]         subfield_ff, subfield_in;
   logic [7:0]         limit_ff, limit_in;
   logic               prev_on_ff, prev_on_in;
   logic [PAT_W-1:0]   drawn_ff, drawn_in;

   logic [DIGIT_W+2:0] idx_ext;
   logic               wr_ok;
   logic [DIGIT_W-1:0] wr_idx;

   function automatic logic [GROUP_W-1:0] to_group(logic [DIGIT_W-1:0] d);
      logic [DIGIT_W+2:0] t;
      t = (DIGIT_W+3)'(d);
      return t[GROUP_W-1:0];
   endfunction

   assign idx_ext = (DIGIT_W+3)'(digit_index);
   assign wr_ok   = idx_ext < (DIGIT_W+3)'(MAX_DIGITS);
   assign wr_idx  = idx_ext[DIGIT_W-1:0];

   always_comb begin
      logic [7:0]             br;
      logic [PAT_W-1:0]       pat;
      logic [DIGIT_SUM_W-1:0] dc_ext;
      logic [DIGIT_SUM_W-1:0] eff;
      logic [DIGIT_SUM_W-1:0] nxt;
      logic [DIGIT_W-1:0]     adv_digit;
      logic [15:0]            product;
      logic [7:0]             lim;
      logic                   lit;
      logic [8:0]             sf;
      logic [1:0]             n;

      br      = bright_ff[cur_digit_ff];
      pat     = pattern_ff[cur_digit_ff];
      dc_ext  = DIGIT_SUM_W'(cfg.digit_count);
      eff     = dc_ext;
      if (cfg.digit_count == 4'd0) begin
         eff = DIGIT_SUM_W'(1);
      end else if (dc_ext > DIGIT_SUM_W'(MAX_DIGITS)) begin
         eff = DIGIT_SUM_W'(MAX_DIGITS);
      end
      nxt       = DIGIT_SUM_W'(cur_digit_ff) + DIGIT_SUM_W'(1);
      adv_digit = (nxt >= eff) ? '0 : nxt[DIGIT_W-1:0];
      product   = 16'(cfg.subfield_count) * 16'(br);
      lim       = limit_ff;
      lit       = prev_on_ff;
      sf        = '0;
      n         = '0;

      bundle        = '0;
      cur_digit_in  = cur_digit_ff;
      prev_digit_in = prev_digit_ff;
      subfield_in   = subfield_ff;
      limit_in      = limit_ff;
      prev_on_in    = prev_on_ff;
      drawn_in      = drawn_ff;

      if (!cfg.sleeping) begin
         // leave the old digit dark before touching the segment lines
         if (cur_digit_ff != prev_digit_ff) begin
            bundle.ent[n] = make_cmd(CMD_DISABLE, to_group(prev_digit_ff), '0);
            n = n + 2'd1;
            lit = 1'b0;
            lim = product[15:8];
         end
         if (cfg.subfield_count == 8'd1) begin
            if (br == 8'd0) begin
               bundle.ent[n] = make_cmd(CMD_DISABLE, to_group(cur_digit_ff), '0);
               n = n + 2'd1;
            end else begin
               if (pat != drawn_ff) begin
                  bundle.ent[n] = make_cmd(CMD_DRAW, '0, SEGMENTS_W'(pat));
                  n = n + 2'd1;
                  drawn_in = pat;
               end
               bundle.ent[n] = make_cmd(CMD_ENABLE, to_group(cur_digit_ff), '0);
               n = n + 2'd1;
            end
            prev_digit_in = cur_digit_ff;
            cur_digit_in  = adv_digit;
         end else begin
            if (br != FULL_BRIGHTNESS && subfield_ff >= lim) begin
               if (lit) begin
                  bundle.ent[n] = make_cmd(CMD_DISABLE, to_group(cur_digit_ff), '0);
                  n = n + 2'd1;
                  lit = 1'b0;
               end
            end else if (!lit) begin
               if (pat != drawn_ff) begin
                  bundle.ent[n] = make_cmd(CMD_DRAW, '0, SEGMENTS_W'(pat));
                  n = n + 2'd1;
                  drawn_in = pat;
               end
               bundle.ent[n] = make_cmd(CMD_ENABLE, to_group(cur_digit_ff), '0);
               n = n + 2'd1;
               lit = 1'b1;
            end
            sf            = 9'(subfield_ff) + 9'd1;
            prev_digit_in = cur_digit_ff;
            prev_on_in    = lit;
            limit_in      = lim;
            if (sf >= 9'(cfg.subfield_count)) begin
               cur_digit_in = adv_digit;
               subfield_in  = '0;
            end else begin
               subfield_in  = sf[7:0];
            end
         end
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            pattern_ff[i] <= '0;
            bright_ff[i]  <= '0;
         end
         cur_digit_ff  <= '0;
         prev_digit_ff <= '0;
         subfield_ff   <= '0;
         limit_ff      <= '0;
         prev_on_ff    <= 1'b0;
         drawn_ff      <= '0;
      end else if (step) begin
         if (kind) begin
            if (wr_ok) begin
               pattern_ff[wr_idx] <= pattern_in[PAT_W-1:0];
               bright_ff[wr_idx]  <= brightness_in;
            end
         end else begin
            cur_digit_ff  <= cur_digit_in;
            prev_digit_ff <= prev_digit_in;
            subfield_ff   <= subfield_in;
            limit_ff      <= limit_in;
            prev_on_ff    <= prev_on_in;
            drawn_ff      <= drawn_in;
         end
      end
   end

   // an enable closes the run: nothing follows it in the same tick
   a_enable_last: assert property (@(posedge clock) disable iff (reset)
      (step && !kind && bundle.count == 2'd3) |->
         (bundle.ent[0].command != CMD_ENABLE && bundle.ent[1].command != CMD_ENABLE))
      else $error("enable command not at end of tick");

   // a draw is always followed directly by an enable of the current digit
   a_draw_enable: assert property (@(posedge clock) disable iff (reset)
      (step && !kind && bundle.count != 2'd0 && bundle.ent[0].command == CMD_DRAW) |->
         (bundle.count == 2'd2 && bundle.ent[1].command == CMD_ENABLE
          && bundle.ent[1].group == to_group(cur_digit_ff)))
      else $error("draw not followed by enable");

endmodule

[design/lds_out.sv]
`timescale 1ns / 1ps

module lds_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  lds_pkg::bundle_type                  bundle,
   output logic                                 slot_free,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lds_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast
);
   import lds_pkg::*;

   cmd_type [BUNDLE_DEPTH-1:0] ent_ff;
   logic [1:0]                 cnt_ff, cnt_in;
   logic [1:0]                 pos_ff, pos_in;
   cmd_type                    cur;

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tlast  = cnt_ff == 2'd1;
   assign slot_free  = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);

   always_comb begin
      unique case (pos_ff)
         2'd0:    cur = ent_ff[0];
         2'd1:    cur = ent_ff[1];
         2'd2:    cur = ent_ff[2];
         default: cur = '0;
      endcase
   end

   assign rsp_tdata = {3'b000, cur.segments, cur.group, cur.command};

   always_comb begin
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (load) begin
         cnt_in = bundle.count;
         pos_in = '0;
      end else if (rsp_tvalid && rsp_tready) begin
         cnt_in = cnt_ff - 2'd1;
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= bundle.ent;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> slot_free)
      else $error("bundle loaded over pending commands");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (3'(pos_ff) + 3'(cnt_ff) <= 3'(BUNDLE_DEPTH)))
      else $error("command pointer out of range");

endmodule

[design/led_digit_scan_pwm_driver_top.sv]
`timescale 1ns / 1ps

// Multiplexed LED digit scanner with per-digit PWM brightness.
//
// req_*  : requests. tuser = kind (0 scan tick, 1 digit write). A write stores
//          a digit's segment pattern and brightness and yields no commands.
//          A tick does one scan step and yields zero to three commands.
// rsp_*  : commands (disable group, draw segments, enable group); tlast marks
//          the final command of a tick.
// csr_*  : register writes, always ready: 0 digit_count, 1 subfield_count,
//          2 sleeping. Write them only while the block is idle.
//
// The first command of a tick leaves after the input register, then the command
// register. Requests are taken one per cycle unless a tick waits in the input
// register for the command register to be free; the commands of a tick leave
// one per cycle while the receiver is ready, so the output port sets the rate
// for ticks. A new request is staged and its scan step computed while the
// previous tick's commands drain.
// Reset clears the digit tables and scan state and sets one digit, one
// subfield, awake. When the receiver stalls, commands hold, the next tick
// waits in the input register, and req_tready drops once that is full.
module led_digit_scan_pwm_driver_top #(
   parameter int MAX_DIGITS   = 8,
   parameter int PATTERN_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [2:0] digit_index, [10:3] pattern_in, [18:11] brightness_in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lds_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tuser,   // kind
   // command: [1:0] command, [4:2] group, [12:5] segments
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lds_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lds_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lds_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lds_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic [2:0] in_idx_ff;
   logic [7:0] in_pat_ff;
   logic [7:0] in_bri_ff;

   cfg_type    cfg_ff;
   bundle_type bundle;
   logic       slot_free;
   logic       step;
   logic       load;

   // a write never waits for the command register; a tick needs it free
   assign step       = in_valid_ff && (in_kind_ff || slot_free);
   assign load       = step && !in_kind_ff;
   assign req_tready = !in_valid_ff || step;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the payload until the scan step takes it
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_idx_ff  <= req_tdata[2:0];
         in_pat_ff  <= req_tdata[10:3];
         in_bri_ff  <= req_tdata[18:11];
      end
   end

   // configuration registers; unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.digit_count    <= 4'd1;
         cfg_ff.subfield_count <= 8'd1;
         cfg_ff.sleeping       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DIGIT_COUNT:    cfg_ff.digit_count    <= csr_wdata[3:0];
            REG_SUBFIELD_COUNT: cfg_ff.subfield_count <= csr_wdata;
            REG_SLEEPING:       cfg_ff.sleeping       <= csr_wdata[0];
            default:            ;
         endcase
      end
   end

   lds_core #(
      .MAX_DIGITS   (MAX_DIGITS),
      .PATTERN_BITS (PATTERN_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .kind          (in_kind_ff),
      .digit_index   (in_idx_ff),
      .pattern_in    (in_pat_ff),
      .brightness_in (in_bri_ff),
      .cfg           (cfg_ff),
      .bundle        (bundle)
   );

   lds_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .bundle     (bundle),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
